### hdl/pnc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the palette nearest-color match block.
// No dependencies.
package pnc_pkg;

  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int IDX_IN_W = 8;
  localparam int RANK_W   = 3;
  localparam int DIST_W   = 10;
  localparam int WDIST_W  = 11;
  localparam int USAGE_W  = 32;

  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 10'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_MATCH,
    RES_READ
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     pal_wr;
    logic     clr_wr;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     scan;
    logic     best_init;
    logic     cnt_rd_item;
    logic     cnt_rd_best;
    logic     cnt_wr_best;
    logic     worst_upd;
    logic     res_load;
    res_sel_t res_sel;
  } pnc_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } pnc_stat_t;

endpackage

### hdl/palette_nearest_color_match.sv
`timescale 1ns / 1ps
// Palette nearest-color match: Chebyshev search over a palette with usage
// histogram and worst-match list.
// Depends on pnc_pkg, pnc_ctrl and pnc_datapath.
//
// Input channel: an item is taken at a clock edge with start high and busy low.
// in_kind selects write palette entry, match color, read statistics, or no-op.
// Result channel: every item yields one result, shown for exactly one cycle
// with out_valid high; the receiver takes it at the edge that ends that cycle.
// Sequencing per kind:
//   write / no-op: result in the next cycle, busy stays low, one item a cycle.
//   read: the result follows state S_READ; busy high for one cycle.
//   match: busy stays high while the palette memory read port is scanned one
//   entry per cycle; states S_DRAIN, S_CNT_RD and S_CNT_WR then drain the
//   compare stage, read and write the usage count, before the result is shown.
// Reset: a clearing pass over all PALETTE_ENTRIES entries zeroes the palette
// allocated flags and the usage counts; busy stays high until it finishes.
// The worst list resets to empty at once.
// Results are never held back: the receiver cannot stall the block.
module palette_nearest_color_match import pnc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int WORST_DEPTH     = 5,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic [IDX_IN_W-1:0]       in_index,
  input  logic [CHAN_W-1:0]         in_red,
  input  logic [CHAN_W-1:0]         in_green,
  input  logic [CHAN_W-1:0]         in_blue,
  input  logic                      in_allocated,
  input  logic [RANK_W-1:0]         in_rank,
  output logic                      out_valid,
  output logic [IDX_IN_W-1:0]       out_best_index,
  output logic [DIST_W-1:0]         out_distance,
  output logic [USAGE_W-1:0]        out_usage_count,
  output logic                      out_new_worst,
  output logic [CHAN_W-1:0]         out_worst_red,
  output logic [CHAN_W-1:0]         out_worst_green,
  output logic [CHAN_W-1:0]         out_worst_blue,
  output logic signed [WDIST_W-1:0] out_worst_dist
);

  pnc_cmd_t  cmd;
  pnc_stat_t stat;

  pnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pnc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .WORST_DEPTH     (WORST_DEPTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_index        (in_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_allocated    (in_allocated),
    .in_rank         (in_rank),
    .out_best_index  (out_best_index),
    .out_distance    (out_distance),
    .out_usage_count (out_usage_count),
    .out_new_worst   (out_new_worst),
    .out_worst_red   (out_worst_red),
    .out_worst_green (out_worst_green),
    .out_worst_blue  (out_worst_blue),
    .out_worst_dist  (out_worst_dist)
  );

endmodule

### hdl/pnc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clear, write, scan, count update and read.
// Depends on pnc_pkg.
module pnc_ctrl import pnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  input  pnc_stat_t         stat,
  output pnc_cmd_t          cmd,
  output logic              busy,
  output logic              out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CNT_RD,
    S_CNT_WR,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = RES_ZERO;
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_WRITE: begin
              cmd.pal_wr    = 1'b1;
              cmd.res_load  = 1'b1;
              out_valid_nxt = 1'b1;
            end
            KIND_MATCH: begin
              cmd.cnt_clr   = 1'b1;
              cmd.best_init = 1'b1;
              state_nxt     = S_SCAN;
              busy_nxt      = 1'b1;
            end
            KIND_READ: begin
              cmd.cnt_rd_item = 1'b1;
              state_nxt       = S_READ;
              busy_nxt        = 1'b1;
            end
            KIND_NONE: begin
              cmd.res_load  = 1'b1;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CNT_RD;
      end
      S_CNT_RD: begin
        cmd.cnt_rd_best = 1'b1;
        state_nxt       = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.cnt_wr_best = 1'b1;
        cmd.worst_upd   = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_sel     = RES_MATCH;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
        busy_nxt        = 1'b0;
      end
      S_READ: begin
        cmd.res_load  = 1'b1;
        cmd.res_sel   = RES_READ;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        busy_nxt      = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_WRITE || in_kind == KIND_NONE)) |=> out_valid)
    else $error("write or no-op item gave no result in the next cycle");

  a_match_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_MATCH) |=> (busy && !out_valid))
    else $error("match item did not hold the block busy");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_READ) |=> busy ##1 out_valid)
    else $error("read item result not two cycles after accept");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (busy && !out_valid))
    else $error("activity during clearing pass");
`endif

endmodule

### hdl/pnc_datapath.sv
`timescale 1ns / 1ps
// Datapath: palette and usage memories, distance compare, worst list, result registers.
// Depends on pnc_pkg; driven by pnc_ctrl commands.
module pnc_datapath import pnc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int WORST_DEPTH     = 5,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pnc_cmd_t                  cmd,
  output pnc_stat_t                 stat,
  input  logic [IDX_IN_W-1:0]       in_index,
  input  logic [CHAN_W-1:0]         in_red,
  input  logic [CHAN_W-1:0]         in_green,
  input  logic [CHAN_W-1:0]         in_blue,
  input  logic                      in_allocated,
  input  logic [RANK_W-1:0]         in_rank,
  output logic [IDX_IN_W-1:0]       out_best_index,
  output logic [DIST_W-1:0]         out_distance,
  output logic [USAGE_W-1:0]        out_usage_count,
  output logic                      out_new_worst,
  output logic [CHAN_W-1:0]         out_worst_red,
  output logic [CHAN_W-1:0]         out_worst_green,
  output logic [CHAN_W-1:0]         out_worst_blue,
  output logic signed [WDIST_W-1:0] out_worst_dist
);

  localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int WIDX_W = (WORST_DEPTH > 1) ? $clog2(WORST_DEPTH) : 1;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [IDX_W-1:0]       cnt_r;
  logic [COLOR_W-1:0]     color_r;
  logic [RANK_W-1:0]      rank_r;
  logic                   idx_ok_r;
  logic [COLOR_W:0]       pal_mem [PALETTE_ENTRIES];
  logic [COLOR_W:0]       pal_q_r;
  logic                   scan_q_r;
  logic [IDX_W-1:0]       idx_q_r;
  logic [IDX_W-1:0]       best_r;
  logic [DIST_W-1:0]      best_d_r;
  logic [COUNT_WIDTH-1:0] cnt_mem [PALETTE_ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_q_r;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [COLOR_W-1:0]     worst_c_r [WORST_DEPTH];
  logic signed [WDIST_W-1:0] worst_d_r [WORST_DEPTH];

  logic [IDX_W-1:0]       in_addr;
  logic                   in_ok;
  logic [CHAN_W-1:0]      dr, dg, db, dmax_rg;
  logic [DIST_W-1:0]      cand_d;
  logic                   enter;
  logic                   rank_ok;
  logic [WIDX_W-1:0]      wsel;
  logic [COLOR_W-1:0]     rd_color;
  logic signed [WDIST_W-1:0] rd_dist;

  assign in_addr       = IDX_W'(in_index);
  assign in_ok         = 32'(in_index) < 32'(PALETTE_ENTRIES);
  assign stat.cnt_last = (cnt_r == IDX_W'(PALETTE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr || (cmd.cnt_inc && stat.cnt_last)) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color_r  <= {in_red, in_green, in_blue};
      rank_r   <= in_rank;
      idx_ok_r <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      pal_mem[cnt_r] <= '0;
    end else if (cmd.pal_wr && in_ok) begin
      pal_mem[in_addr] <= {in_allocated, in_red, in_green, in_blue};
    end
    pal_q_r <= pal_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_q_r <= 1'b0;
    end else begin
      scan_q_r <= cmd.scan;
    end
    idx_q_r <= cnt_r;
  end

  assign dr      = abs_diff(pal_q_r[3*CHAN_W-1:2*CHAN_W], color_r[3*CHAN_W-1:2*CHAN_W]);
  assign dg      = abs_diff(pal_q_r[2*CHAN_W-1:CHAN_W], color_r[2*CHAN_W-1:CHAN_W]);
  assign db      = abs_diff(pal_q_r[CHAN_W-1:0], color_r[CHAN_W-1:0]);
  assign dmax_rg = (dg > dr) ? dg : dr;
  assign cand_d  = DIST_W'((db > dmax_rg) ? db : dmax_rg);

  always_ff @(posedge clk) begin
    if (cmd.best_init) begin
      best_r   <= '0;
      best_d_r <= NO_MATCH_DIST;
    end else if (scan_q_r && pal_q_r[COLOR_W] && (cand_d < best_d_r)) begin
      best_r   <= idx_q_r;
      best_d_r <= cand_d;
    end
  end

  assign cnt_new = (&cnt_q_r) ? cnt_q_r : cnt_q_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cnt_mem[cnt_r] <= '0;
    end else if (cmd.cnt_wr_best) begin
      cnt_mem[best_r] <= cnt_new;
    end
    if (cmd.cnt_rd_item || cmd.cnt_rd_best) begin
      cnt_q_r <= cnt_mem[cmd.cnt_rd_item ? in_addr : best_r];
    end
  end

  assign enter = $signed({1'b0, best_d_r}) > worst_d_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WORST_DEPTH; k++) begin
        worst_c_r[k] <= '0;
        worst_d_r[k] <= -11'sd1;
      end
    end else if (cmd.worst_upd && enter) begin
      for (int k = WORST_DEPTH - 1; k > 0; k--) begin
        worst_c_r[k] <= worst_c_r[k-1];
        worst_d_r[k] <= worst_d_r[k-1];
      end
      worst_c_r[0] <= color_r;
      worst_d_r[0] <= $signed({1'b0, best_d_r});
    end
  end

  assign rank_ok  = 32'(rank_r) < 32'(WORST_DEPTH);
  assign wsel     = WIDX_W'(rank_r);
  assign rd_color = rank_ok ? worst_c_r[wsel] : '0;
  assign rd_dist  = rank_ok ? worst_d_r[wsel] : -11'sd1;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_MATCH: begin
          out_best_index  <= IDX_IN_W'(best_r);
          out_distance    <= best_d_r;
          out_usage_count <= USAGE_W'(cnt_new);
          out_new_worst   <= enter;
          out_worst_red   <= '0;
          out_worst_green <= '0;
          out_worst_blue  <= '0;
          out_worst_dist  <= '0;
        end
        RES_READ: begin
          out_best_index  <= '0;
          out_distance    <= '0;
          out_usage_count <= idx_ok_r ? USAGE_W'(cnt_q_r) : '0;
          out_new_worst   <= 1'b0;
          out_worst_red   <= rd_color[3*CHAN_W-1:2*CHAN_W];
          out_worst_green <= rd_color[2*CHAN_W-1:CHAN_W];
          out_worst_blue  <= rd_color[CHAN_W-1:0];
          out_worst_dist  <= rd_dist;
        end
        default: begin
          out_best_index  <= '0;
          out_distance    <= '0;
          out_usage_count <= '0;
          out_new_worst   <= 1'b0;
          out_worst_red   <= '0;
          out_worst_green <= '0;
          out_worst_blue  <= '0;
          out_worst_dist  <= '0;
        end
      endcase
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for palette_nearest_color_match: directed and random items of all four
// kinds, each result checked field by field against an in-bench palette search model.
// Depends on pnc_pkg and the palette_nearest_color_match RTL.
module tb;
  import pnc_pkg::*;

  localparam int NUM_ENTRIES = 256;
  localparam int LIST_DEPTH  = 5;
  localparam int EMPTY_DIST  = -1;
  localparam int NONE_DIST   = 1000;
  localparam int NUM_RANDOM  = 1000;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    kind_t               kind;
    logic [IDX_IN_W-1:0] index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                allocated;
    logic [RANK_W-1:0]   rank;
    int                  gap_pct;
    bit                  drain;
  } pal_item_t;

  typedef struct {
    logic [IDX_IN_W-1:0]        best_index;
    logic [DIST_W-1:0]          distance;
    logic [USAGE_W-1:0]         usage_count;
    logic                       new_worst;
    logic [CHAN_W-1:0]          worst_red;
    logic [CHAN_W-1:0]          worst_green;
    logic [CHAN_W-1:0]          worst_blue;
    logic signed [WDIST_W-1:0]  list_dist;
  } pal_answer_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [KIND_W-1:0]         in_kind = KIND_WRITE;
  logic [IDX_IN_W-1:0]       in_index = '0;
  logic [CHAN_W-1:0]         in_red = '0;
  logic [CHAN_W-1:0]         in_green = '0;
  logic [CHAN_W-1:0]         in_blue = '0;
  logic                      in_allocated = 1'b0;
  logic [RANK_W-1:0]         in_rank = '0;
  logic                      out_valid;
  logic [IDX_IN_W-1:0]       out_best_index;
  logic [DIST_W-1:0]         out_distance;
  logic [USAGE_W-1:0]        out_usage_count;
  logic                      out_new_worst;
  logic [CHAN_W-1:0]         out_worst_red;
  logic [CHAN_W-1:0]         out_worst_green;
  logic [CHAN_W-1:0]         out_worst_blue;
  logic signed [WDIST_W-1:0] out_worst_dist;

  pal_item_t   items_to_send[$];
  pal_answer_t answer_q[$];
  pal_item_t   shown;
  int          errors = 0;
  int          cycle_count = 0;

  logic [COLOR_W-1:0] pal_color [NUM_ENTRIES];
  bit                 pal_alloc [NUM_ENTRIES];
  logic [USAGE_W-1:0] hit_count [NUM_ENTRIES];
  logic [COLOR_W-1:0] worst_color [LIST_DEPTH];
  int                 worst_dist [LIST_DEPTH];

  logic [COLOR_W-1:0] gen_color [NUM_ENTRIES];
  bit                 gen_known [NUM_ENTRIES];

  palette_nearest_color_match i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_index        (in_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_allocated    (in_allocated),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_best_index  (out_best_index),
    .out_distance    (out_distance),
    .out_usage_count (out_usage_count),
    .out_new_worst   (out_new_worst),
    .out_worst_red   (out_worst_red),
    .out_worst_green (out_worst_green),
    .out_worst_blue  (out_worst_blue),
    .out_worst_dist  (out_worst_dist)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic int clamp_chan(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // Update the palette state for one item and return its answer.
  function automatic pal_answer_t compute_answer(pal_item_t it);
    pal_answer_t        ans;
    logic [COLOR_W-1:0] c;
    int                 best;
    int                 best_d;
    int                 d;
    int                 dg;
    int                 db;
    int                 k;
    ans = '{default: '0};
    case (it.kind)
      KIND_WRITE: begin
        pal_color[it.index] = {it.red, it.green, it.blue};
        pal_alloc[it.index] = it.allocated;
      end
      KIND_MATCH: begin
        best = 0;
        best_d = NONE_DIST;
        for (k = 0; k < NUM_ENTRIES; k++) begin
          if (pal_alloc[k]) begin
            c = pal_color[k];
            d = chan_gap(c[23:16], it.red);
            dg = chan_gap(c[15:8], it.green);
            db = chan_gap(c[7:0], it.blue);
            if (dg > d) d = dg;
            if (db > d) d = db;
            if (d < best_d) begin
              best = k;
              best_d = d;
            end
          end
        end
        if (best_d > worst_dist[0]) begin
          for (k = LIST_DEPTH - 1; k > 0; k--) begin
            worst_color[k] = worst_color[k-1];
            worst_dist[k] = worst_dist[k-1];
          end
          worst_color[0] = {it.red, it.green, it.blue};
          worst_dist[0] = best_d;
          ans.new_worst = 1'b1;
        end
        if (hit_count[best] != '1) hit_count[best] = hit_count[best] + 1'b1;
        ans.best_index = IDX_IN_W'(best);
        ans.distance = DIST_W'(best_d);
        ans.usage_count = hit_count[best];
      end
      KIND_READ: begin
        ans.usage_count = hit_count[it.index];
        c = '0;
        d = EMPTY_DIST;
        if (it.rank < LIST_DEPTH) begin
          c = worst_color[it.rank];
          d = worst_dist[it.rank];
        end
        ans.worst_red = c[23:16];
        ans.worst_green = c[15:8];
        ans.worst_blue = c[7:0];
        ans.list_dist = WDIST_W'(d);
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic void add_item(kind_t k, int idx, int r, int g, int b, bit al, int rk,
                                   int gap, bit drain);
    pal_item_t it;
    it.kind = k;
    it.index = IDX_IN_W'(idx);
    it.red = CHAN_W'(r);
    it.green = CHAN_W'(g);
    it.blue = CHAN_W'(b);
    it.allocated = al;
    it.rank = RANK_W'(rk);
    it.gap_pct = gap;
    it.drain = drain;
    items_to_send.push_back(it);
    if (k == KIND_WRITE) begin
      gen_color[it.index] = {it.red, it.green, it.blue};
      gen_known[it.index] = al;
    end
  endfunction

  // Writes often copy an allocated color (ties), matches often land near one.
  function automatic void add_random(int gap, bit drain);
    int    sel;
    int    src;
    int    r;
    int    g;
    int    b;
    int    spread;
    kind_t k;
    sel = $urandom_range(99);
    r = $urandom_range(255);
    g = $urandom_range(255);
    b = $urandom_range(255);
    src = $urandom_range(NUM_ENTRIES - 1);
    if (sel < 40) k = KIND_WRITE;
    else if (sel < 75) k = KIND_MATCH;
    else if (sel < 95) k = KIND_READ;
    else k = KIND_NONE;
    if (gen_known[src] && k != KIND_READ && $urandom_range(2) != 0) begin
      spread = (k == KIND_WRITE) ? 0 : 8;
      r = clamp_chan(int'(gen_color[src][23:16]) + int'($urandom_range(2 * spread)) - spread);
      g = clamp_chan(int'(gen_color[src][15:8]) + int'($urandom_range(2 * spread)) - spread);
      b = clamp_chan(int'(gen_color[src][7:0]) + int'($urandom_range(2 * spread)) - spread);
    end
    add_item(k, $urandom_range(255), r, g, b, $urandom_range(3) != 0, $urandom_range(7),
             gap, drain);
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Present the next item once the current one is taken; model it at acceptance.
  always @(posedge clk) begin
    bit taken;
    bit send;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) answer_q.push_back(compute_answer(shown));
      if (!start || taken) begin
        send = items_to_send.size() != 0;
        if (send && items_to_send[0].drain && (answer_q.size() != 0 || out_valid))
          send = 1'b0;
        if (send && $urandom_range(99) < items_to_send[0].gap_pct) send = 1'b0;
        if (send) begin
          shown = items_to_send.pop_front();
          in_kind <= shown.kind;
          in_index <= shown.index;
          in_red <= shown.red;
          in_green <= shown.green;
          in_blue <= shown.blue;
          in_allocated <= shown.allocated;
          in_rank <= shown.rank;
        end
        start <= send;
      end
    end
  end

  always @(posedge clk) begin
    pal_answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual index %0d distance %0d",
                 $time, out_best_index, out_distance);
      end else begin
        want = answer_q.pop_front();
        check_field("best_index", want.best_index, out_best_index);
        check_field("distance", want.distance, out_distance);
        check_field("usage_count", want.usage_count, out_usage_count);
        check_field("new_worst", want.new_worst, out_new_worst);
        check_field("worst_red", want.worst_red, out_worst_red);
        check_field("worst_green", want.worst_green, out_worst_green);
        check_field("worst_blue", want.worst_blue, out_worst_blue);
        check_field("worst_dist", want.list_dist, out_worst_dist);
      end
    end
  end

  initial begin
    int i;
    int gap;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      pal_color[i] = '0;
      pal_alloc[i] = 1'b0;
      hit_count[i] = '0;
      gen_color[i] = '0;
      gen_known[i] = 1'b0;
    end
    for (i = 0; i < LIST_DEPTH; i++) begin
      worst_color[i] = '0;
      worst_dist[i] = EMPTY_DIST;
    end

    // sparse palette: extremes, an unallocated entry, ties resolved to the lowest index
    add_item(KIND_WRITE, 0, 0, 0, 0, 1, 0, 0, 0);
    add_item(KIND_WRITE, 255, 255, 255, 255, 1, 7, 0, 0);
    add_item(KIND_WRITE, 10, 16, 32, 48, 0, 0, 0, 0);
    add_item(KIND_MATCH, 0, 127, 127, 127, 0, 0, 0, 0);
    add_item(KIND_MATCH, 255, 128, 128, 128, 1, 7, 0, 0);
    add_item(KIND_MATCH, 0, 255, 255, 255, 0, 0, 0, 0);
    add_item(KIND_WRITE, 20, 64, 64, 64, 1, 0, 0, 0);
    add_item(KIND_WRITE, 30, 64, 64, 64, 1, 0, 0, 0);
    add_item(KIND_MATCH, 0, 64, 64, 64, 0, 0, 0, 0);
    add_item(KIND_MATCH, 0, 32, 32, 32, 0, 0, 0, 0);
    add_item(KIND_MATCH, 0, 16, 32, 48, 0, 0, 0, 0);
    add_item(KIND_WRITE, 255, 255, 255, 255, 0, 0, 0, 0);
    add_item(KIND_MATCH, 0, 96, 80, 64, 0, 0, 0, 0);
    add_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_READ, 255, 255, 255, 255, 1, 1, 0, 0);
    add_item(KIND_READ, 20, 0, 0, 0, 0, 4, 0, 0);
    add_item(KIND_READ, 20, 0, 0, 0, 0, 5, 0, 0);
    add_item(KIND_READ, 30, 0, 0, 0, 0, 7, 0, 0);
    add_item(KIND_NONE, 255, 255, 255, 255, 1, 7, 0, 0);
    add_item(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_READ, 10, 0, 0, 0, 0, 2, 0, 1);

    for (i = 0; i < NUM_RANDOM; i++) begin
      gap = (i < NUM_RANDOM / 3) ? 34 : ((i < 2 * NUM_RANDOM / 3) ? 66 : 0);
      add_random(gap, (i % 250) == 249);
    end

    // deallocate everything, then match with an empty palette and dump the list
    for (i = 0; i < NUM_ENTRIES; i++)
      add_item(KIND_WRITE, i, $urandom_range(255), $urandom_range(255), $urandom_range(255),
               0, $urandom_range(7), 0, i == 0);
    add_item(KIND_MATCH, $urandom_range(255), 200, 100, 50, 1, 0, 0, 0);
    for (i = 0; i < 8; i++)
      add_item(KIND_READ, 0, 0, 0, 0, 0, i, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while ((items_to_send.size() != 0 || start || answer_q.size() != 0)
           && cycle_count < CYCLE_LIMIT)
      @(negedge clk);
    if (cycle_count < CYCLE_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && cycle_count < CYCLE_LIMIT) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

### files.f
hdl/pnc_pkg.sv
hdl/pnc_ctrl.sv
hdl/pnc_datapath.sv
hdl/palette_nearest_color_match.sv
tb/sv/tb.sv
